>>> design/float_to_decimal_text_defines.svh
// ----------------------------------------------------------------------------
// Float to decimal text: assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef FLOAT_TO_DECIMAL_TEXT_DEFINES_SVH
`define FLOAT_TO_DECIMAL_TEXT_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define FDT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define FDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/fdt_pkg.sv
// ----------------------------------------------------------------------------
// Float to decimal text: package
// Field widths, exponent limits, ASCII codes and controller/datapath types.
// ----------------------------------------------------------------------------
package fdt_pkg;

  localparam int FLOAT_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int EXP_W      = 8;
  localparam int MANT_W     = 24;
  localparam int INT_W      = 19;
  localparam int MAX_CHARS  = 7;
  localparam int MAX_DIGITS = 6;
  localparam int FRAC_DIGS  = 4;
  localparam int FRAC_ROOM  = 5;

  localparam int EXP_BIAS = 127;
  localparam int E_MAX    = 18;
  localparam int E_MIN    = -4;
  localparam int EXP_HI   = EXP_BIAS + E_MAX;   // above this: Inf
  localparam int EXP_LO   = EXP_BIAS + E_MIN;   // below this: 0
  localparam int INT_SHIFT_BASE = EXP_BIAS + 23;
  localparam int NIB_SHIFT_BASE = EXP_BIAS + 19;

  // ceil(2^23 / 10), exact quotient for any 19-bit dividend
  localparam logic [19:0] RECIP10 = 20'hCCCCD;
  localparam int RECIP_SHIFT = 23;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_UP_I  = 8'h49;
  localparam logic [CHAR_W-1:0] CH_LO_N  = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;

  typedef logic [2:0] len_t;

  typedef struct packed {
    logic load;
    logic step;
    logic build;
    logic adv;
  } fdt_cmd_t;

  typedef struct packed {
    logic digit_last;
    logic char_last;
  } fdt_stat_t;

  // n * 625 as four BCD digits
  function automatic logic [15:0] frac_bcd(input logic [3:0] nib);
    logic [15:0] r;
    unique case (nib)
      4'd0:  r = 16'h0000;
      4'd1:  r = 16'h0625;
      4'd2:  r = 16'h1250;
      4'd3:  r = 16'h1875;
      4'd4:  r = 16'h2500;
      4'd5:  r = 16'h3125;
      4'd6:  r = 16'h3750;
      4'd7:  r = 16'h4375;
      4'd8:  r = 16'h5000;
      4'd9:  r = 16'h5625;
      4'd10: r = 16'h6250;
      4'd11: r = 16'h6875;
      4'd12: r = 16'h7500;
      4'd13: r = 16'h8125;
      4'd14: r = 16'h8750;
      4'd15: r = 16'h9375;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

>>> design/fdt_ctrl.sv
// ----------------------------------------------------------------------------
// Float to decimal text: controller
// Sequences load, digit conversion, text build and character output.
// ----------------------------------------------------------------------------
module fdt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fdt_pkg::fdt_stat_t stat,
  output fdt_pkg::fdt_cmd_t  cmd
);
  import fdt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_BUILD = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (stat.digit_last) begin
          state_nxt = ST_BUILD;
        end
      end
      ST_BUILD: begin
        cmd.build = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.adv = 1'b1;
          if (stat.char_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/fdt_datapath.sv
// ----------------------------------------------------------------------------
// Float to decimal text: datapath
// Unpacks the float, peels decimal digits one per step, composes the text.
// ----------------------------------------------------------------------------
module fdt_datapath (
  input  logic                         clk,
  input  logic [fdt_pkg::FLOAT_W-1:0]  in_float_bits,
  input  fdt_pkg::fdt_cmd_t            cmd,
  output fdt_pkg::fdt_stat_t           stat,
  output logic [fdt_pkg::CHAR_W-1:0]   out_text_char,
  output logic                         out_last_char
);
  import fdt_pkg::*;

  logic                 sign_r;
  logic                 is_inf_r;
  logic                 is_zero_r;
  logic [INT_W-1:0]     ipart_r;
  logic [3:0]           nib_r;
  logic [3:0]           digits_r [MAX_DIGITS];
  len_t                 nd_r;
  logic [CHAR_W-1:0]    text_r [MAX_CHARS];
  len_t                 len_r;
  len_t                 idx_r;

  // unpack
  logic [EXP_W-1:0]  exp_f;
  logic [MANT_W-1:0] mant;
  logic [EXP_W-1:0]  sh_int;
  logic [EXP_W-1:0]  sh_nib;
  logic [MANT_W-1:0] int_full;
  logic [MANT_W-1:0] nib_full;
  logic              load_inf;
  logic              load_zero;

  assign exp_f     = in_float_bits[30:23];
  assign mant      = {1'b1, in_float_bits[22:0]};
  assign load_inf  = exp_f > EXP_W'(EXP_HI);
  assign load_zero = exp_f < EXP_W'(EXP_LO);
  assign sh_int    = EXP_W'(INT_SHIFT_BASE) - exp_f;
  assign sh_nib    = EXP_W'(NIB_SHIFT_BASE) - exp_f;
  assign int_full  = mant >> sh_int[4:0];
  assign nib_full  = mant >> sh_nib[4:0];

  // divide by ten via reciprocal
  logic [38:0]      prod;
  logic [INT_W-1:0] quot;
  logic [INT_W-1:0] rem_full;

  assign prod     = 39'(ipart_r) * 39'(RECIP10);
  assign quot     = INT_W'(prod[38:RECIP_SHIFT]);
  assign rem_full = ipart_r - ((quot << 3) + (quot << 1));

  // text composition
  logic [15:0]       fbcd;
  logic [CHAR_W-1:0] text_nxt [MAX_CHARS];
  len_t              len_nxt;
  len_t              pos;
  len_t              fidx;
  int                p;

  always_comb begin
    fbcd = frac_bcd(nib_r);
    for (p = 0; p < MAX_CHARS; p++) begin
      text_nxt[p] = CH_ZERO;
    end
    pos  = '0;
    fidx = '0;
    if (is_inf_r) begin
      text_nxt[0] = CH_UP_I;
      text_nxt[1] = CH_LO_N;
      text_nxt[2] = CH_LO_F;
      len_nxt     = len_t'(3);
    end else if (is_zero_r) begin
      text_nxt[0] = CH_ZERO;
      len_nxt     = len_t'(1);
    end else begin
      text_nxt[0] = sign_r ? CH_MINUS : CH_SPACE;
      for (p = 1; p < MAX_CHARS; p++) begin
        pos  = len_t'(p);
        fidx = pos - nd_r - len_t'(2);
        if (pos <= nd_r) begin
          text_nxt[p] = CH_ZERO + CHAR_W'(digits_r[p-1]);
        end else if (pos == nd_r + len_t'(1)) begin
          text_nxt[p] = CH_DOT;
        end else begin
          unique case (fidx[1:0])
            2'd0: text_nxt[p] = CH_ZERO + CHAR_W'(fbcd[15:12]);
            2'd1: text_nxt[p] = CH_ZERO + CHAR_W'(fbcd[11:8]);
            2'd2: text_nxt[p] = CH_ZERO + CHAR_W'(fbcd[7:4]);
            2'd3: text_nxt[p] = CH_ZERO + CHAR_W'(fbcd[3:0]);
            default: text_nxt[p] = CH_ZERO;
          endcase
        end
      end
      // no room for a fraction once sign and digits pass five characters
      if (nd_r >= len_t'(FRAC_ROOM)) begin
        len_nxt = nd_r + len_t'(1);
      end else begin
        len_nxt = len_t'(MAX_CHARS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sign_r    <= in_float_bits[31];
      is_inf_r  <= load_inf;
      is_zero_r <= load_zero;
      ipart_r   <= (load_inf || load_zero) ? '0 : INT_W'(int_full);
      nib_r     <= nib_full[3:0];
      nd_r      <= '0;
    end
    if (cmd.step) begin
      // newest digit is the most significant so far: shift it in at the bottom
      digits_r[0] <= rem_full[3:0];
      for (int k = 1; k < MAX_DIGITS; k++) begin
        digits_r[k] <= digits_r[k-1];
      end
      ipart_r <= quot;
      nd_r    <= nd_r + len_t'(1);
    end
    if (cmd.build) begin
      text_r <= text_nxt;
      len_r  <= len_nxt;
      idx_r  <= '0;
    end
    if (cmd.adv) begin
      idx_r <= idx_r + len_t'(1);
    end
  end

  assign stat.digit_last = (quot == '0);
  assign stat.char_last  = (idx_r == len_r - len_t'(1));
  assign out_text_char   = text_r[idx_r];
  assign out_last_char   = stat.char_last;

endmodule

>>> design/float_to_decimal_text.sv
// ----------------------------------------------------------------------------
// Float to decimal text: top level
// Converts one single-precision bit pattern into up to seven ASCII characters.
// ----------------------------------------------------------------------------
// One float is handled at a time. After a transaction is accepted the block
// produces one decimal digit of the integer part per cycle in its divide-by-
// ten loop, composes the text in its build state, then sends one character
// per cycle while out_ready is high, with out_last_char on the final one.
// in_ready is high only between items; results are held stable while
// out_ready is low.
module float_to_decimal_text (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fdt_pkg::FLOAT_W-1:0] in_float_bits,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fdt_pkg::CHAR_W-1:0]  out_text_char,
  output logic                        out_last_char
);
  import fdt_pkg::*;

  fdt_cmd_t  cmd;
  fdt_stat_t stat;

  fdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fdt_datapath u_datapath (
    .clk           (clk),
    .in_float_bits (in_float_bits),
    .cmd           (cmd),
    .stat          (stat),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

endmodule

>>> design/fdt_checker.sv
// ----------------------------------------------------------------------------
// Float to decimal text: port checker
// Watches the top-level ports for handshake and sequencing errors.
// ----------------------------------------------------------------------------
`include "float_to_decimal_text_defines.svh"

module fdt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [fdt_pkg::CHAR_W-1:0]  out_text_char,
  input logic                        out_last_char
);
  import fdt_pkg::*;

  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  `FDT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_text_char) && $stable(out_last_char), "stalled result changed")
  `FDT_ASSERT_SAME(a_no_overlap, clk, rst_n, in_ready, !out_valid, "input taken while text is pending")
  `FDT_ASSERT_NEXT(a_last_ends, clk, rst_n, out_xfer && out_last_char, !out_valid && in_ready, "text continued after last character")
  `FDT_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_xfer, !in_ready && !out_valid, "no conversion after input transaction")

endmodule

bind float_to_decimal_text fdt_checker u_fdt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_text_char (out_text_char),
  .out_last_char (out_last_char)
);

>>> sim/float_to_decimal_text_checker.sv
// ----------------------------------------------------------------------------
// Float to decimal text: checker
// Watches both channels, predicts the text of every accepted float and checks
// each character and end flag that leaves the block, in order.
// ----------------------------------------------------------------------------
module float_to_decimal_text_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [fdt_pkg::FLOAT_W-1:0] in_float_bits,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [fdt_pkg::CHAR_W-1:0]  out_text_char,
  input  logic                        out_last_char,
  output int                          mismatch_count,
  output int                          chars_pending,
  output int                          chars_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import fdt_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  text_char_t expected_text [$];
  text_char_t oldest;
  int mismatches = 0;
  int compared   = 0;

  // Append the characters that one float turns into.
  function automatic void predict_text(input logic [FLOAT_W-1:0] bits);
    logic [CHAR_W-1:0] txt [MAX_CHARS];
    int digit_vals [8];
    logic [23:0] signif;
    int expo, len, nd, k;
    int unsigned whole, sixteenths, scale;
    signif = {1'b1, bits[22:0]};
    expo   = int'(bits[30:23]) - EXP_BIAS;
    len    = 0;
    nd     = 0;
    if (expo > E_MAX) begin
      txt[0] = CH_UP_I;
      txt[1] = CH_LO_N;
      txt[2] = CH_LO_F;
      len = 3;
    end else if (expo < E_MIN) begin
      txt[0] = CH_ZERO;
      len = 1;
    end else begin
      txt[0] = bits[31] ? CH_MINUS : CH_SPACE;
      len = 1;
      whole = 32'(signif) >> (23 - expo);
      do begin
        digit_vals[nd] = int'(whole % 10);
        nd = nd + 1;
        whole = whole / 10;
      end while (whole != 0);
      for (k = nd - 1; k >= 0 && len < MAX_CHARS; k--) begin
        txt[len] = CH_ZERO + CHAR_W'(digit_vals[k]);
        len = len + 1;
      end
      // Room left: dot and the top four fraction bits in sixteenths.
      if (len <= FRAC_ROOM) begin
        txt[len] = CH_DOT;
        len = len + 1;
        sixteenths = 625 * ((32'(signif) >> (19 - expo)) & 32'hF);
        for (scale = 1000; scale != 0 && len < MAX_CHARS; scale = scale / 10) begin
          txt[len] = CH_ZERO + CHAR_W'((sixteenths / scale) % 10);
          len = len + 1;
        end
      end
    end
    for (k = 0; k < len; k++)
      expected_text.push_back('{ch: txt[k], last: (k == len - 1)});
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_text.delete();
    end else begin
      if (in_valid && in_ready)
        predict_text(in_float_bits);
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected character 0x%02h last=%0b, nothing expected",
                   $time, out_text_char, out_last_char);
        end else begin
          oldest = expected_text.pop_front();
          compared++;
          if (out_text_char !== oldest.ch) begin
            mismatches++;
            $display("%0t: text_char expected 0x%02h actual 0x%02h",
                     $time, oldest.ch, out_text_char);
          end
          if (out_last_char !== oldest.last) begin
            mismatches++;
            $display("%0t: last_char expected %0b actual %0b",
                     $time, oldest.last, out_last_char);
          end
        end
      end
    end
    mismatch_count <= mismatches;
    chars_pending  <= expected_text.size();
    chars_checked  <= compared;
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// Float to decimal text: testbench top
// Feeds directed and random single-precision patterns with random idling on
// both channels, holds the output off once to back up the input, and reports
// the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fdt_pkg::*;

  localparam int ITEM_TARGET    = 220;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [FLOAT_W-1:0] in_float_bits = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [CHAR_W-1:0]  out_text_char;
  logic               out_last_char;

  int mismatch_count;
  int chars_pending;
  int chars_checked;
  int floats_sent    = 0;
  int idle_cycles    = 0;
  bit long_hold_done = 1'b0;

  logic [FLOAT_W-1:0] directed_floats [$] = {
    32'h0000_0000,  // +0
    32'h8000_0000,  // -0
    32'h0000_0001,  // smallest subnormal
    32'h7F80_0000,  // +inf
    32'hFF80_0000,  // -inf
    32'h7FC0_0000,  // NaN
    32'hFFFF_FFFF,
    32'h4900_0000,  // one past the largest shown exponent
    32'h48FF_FFFF,  // largest integer part, six digits
    32'hC8FF_FFFF,
    32'h3D80_0000,  // smallest shown exponent
    32'h3D7F_FFFF,  // one below it
    32'h3F80_0000,
    32'hBFC0_0000,
    32'h3FF8_0000,
    32'h4640_0000,  // five digits, no fraction room
    32'h447A_0000,  // four digits, fraction cut short
    32'hC47A_0000,
    32'h42F6_E979,
    32'h4120_0000,
    32'h3F00_0000,
    32'h3F7F_FFFF
  };

  int border_exps [6] = '{0, 255, EXP_LO - 1, EXP_HI + 1, EXP_LO, EXP_HI};

  initial begin
    forever #2 clk = ~clk;
  end

  float_to_decimal_text i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_float_bits (in_float_bits),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

  float_to_decimal_text_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_float_bits  (in_float_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_text_char  (out_text_char),
    .out_last_char  (out_last_char),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending),
    .chars_checked  (chars_checked)
  );

  // Mostly no gap, some short, a few long.
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic offer_float(input logic [FLOAT_W-1:0] bits);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_float_bits <= bits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    floats_sent++;
  endtask

  // Stimulus
  initial begin
    logic [FLOAT_W-1:0] rand_bits;
    int unsigned roll;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_floats[k])
      offer_float(directed_floats[k]);
    while (floats_sent < ITEM_TARGET) begin
      rand_bits = $urandom();
      roll = $urandom_range(0, 99);
      // Bias toward exponents that produce digits; keep some at the borders.
      if (roll < 75)
        rand_bits[30:23] = 8'($urandom_range(EXP_LO, EXP_HI));
      else if (roll < 88)
        rand_bits[30:23] = 8'(border_exps[$urandom_range(0, 5)]);
      offer_float(rand_bits);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d floats (directed borders, Inf/zero, random exponents), %0d-cycle hold-off;",
             floats_sent, LONG_HOLD);
    $display("%0d characters compared, %0d mismatches.", chars_checked, mismatch_count);
    if (mismatch_count == 0 && chars_pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Receiver: random ready, plus one long hold-off while input keeps coming.
  initial begin
    int unsigned gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!long_hold_done && floats_sent >= 40) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end
      gap = idle_gap();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
